[sv/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/gmmr_pkg.sv]
// Types, constants and helper functions of the grouped min/median/or reduction.
package gmmr_pkg;

    localparam int SCORE_W     = 32;
    localparam int GSUM_W      = 40;
    localparam int RSUM_W      = 48;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = FRAC_BITS + 1;
    localparam int ACC_W       = 96;
    localparam int ROOT_W      = ACC_W / 2;
    localparam int K_W         = 9;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_GENES_DEFAULT  = 16;
    localparam int MAX_GROUPS_DEFAULT = 64;

    localparam logic [PROD_W-1:0] ONE_FX = PROD_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_AND_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OR_MODE  = 1'd1;

    localparam logic [MODE_W-1:0] AND_MIN    = 2'd0;
    localparam logic [MODE_W-1:0] AND_MEDIAN = 2'd1;
    localparam logic [MODE_W-1:0] AND_MEAN   = 2'd2;

    localparam logic [MODE_W-1:0] OR_MAX  = 2'd0;
    localparam logic [MODE_W-1:0] OR_SQRT = 2'd1;
    localparam logic [MODE_W-1:0] OR_PROB = 2'd2;
    localparam logic [MODE_W-1:0] OR_SUM  = 2'd3;

    typedef enum logic {OP_MEAN = 1'b0, OP_SQRT = 1'b1} unit_op_t;

    typedef struct packed {
        logic                      has_gene;
        logic signed [SCORE_W-1:0] gene_score;
        logic                      score_valid;
        logic                      end_group;
        logic                      end_reaction;
    } item_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] capacity;
        logic                      capacity_na;
    } result_t;

    typedef struct packed {
        logic                      ins;
        logic                      shift;
        logic signed [SCORE_W-1:0] ins_val;
    } cell_ctrl_t;

    typedef struct packed {
        logic                     start;
        unit_op_t                 op;
        logic signed [RSUM_W-1:0] value;
        logic [K_W-1:0]           k;
    } unit_req_t;

    function automatic logic signed [SCORE_W-1:0] sat32(input logic signed [RSUM_W-1:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v > RSUM_W'(33'sh0_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -RSUM_W'(33'sh0_8000_0000)) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[SCORE_W-1:0];
        end
        return r;
    endfunction

endpackage

[sv/gmmr_cell.sv]
// One cell of the sorted score chain: insertion from the left, shift toward cell zero.
module gmmr_cell (
    input  logic                               clk,
    input  gmmr_pkg::cell_ctrl_t               ctrl,
    input  logic                               occupied,
    input  logic                               at_count,
    input  logic                               left_gt,
    input  logic signed [gmmr_pkg::SCORE_W-1:0] left_val,
    input  logic signed [gmmr_pkg::SCORE_W-1:0] right_val,
    output logic signed [gmmr_pkg::SCORE_W-1:0] val,
    output logic                               gt
);
    import gmmr_pkg::*;

    logic signed [SCORE_W-1:0] val_reg;

    assign val = val_reg;
    assign gt  = occupied && (val_reg > ctrl.ins_val);

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            if (left_gt)
            begin
                val_reg <= left_val;
            end
            else if (gt || at_count)
            begin
                val_reg <= ctrl.ins_val;
            end
        end
        else if (ctrl.shift)
        begin
            val_reg <= right_val;
        end
    end

endmodule

[sv/gmmr_serial.sv]
// Bit-serial unit for the group mean division and the sum over square root of count.
module gmmr_serial (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gmmr_pkg::unit_req_t                 req,
    output logic                                done,
    output logic signed [gmmr_pkg::SCORE_W-1:0] res
);
    import gmmr_pkg::*;

    localparam int CNT_UW = $clog2(ACC_W + 1);
    localparam int SR_W   = ROOT_W + 2;

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_SQ   = 5'b00010,
        U_DV   = 5'b00100,
        U_RT   = 5'b01000,
        U_DONE = 5'b10000
    } ustate_t;

    ustate_t                  state_reg, state_next;
    logic [CNT_UW-1:0]        cnt_reg, cnt_next;
    unit_op_t                 op_reg, op_next;
    logic                     neg_reg, neg_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic [RSUM_W-1:0]        mag_reg, mag_next;
    logic [RSUM_W-1:0]        msh_reg, msh_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [K_W-1:0]           rem_reg, rem_next;
    logic [SR_W-1:0]          srem_reg, srem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic signed [SCORE_W-1:0] res_reg, res_next;

    logic [K_W:0]             dv_r;
    logic                     dv_ok;
    logic [SR_W+1:0]          rt_t;
    logic [SR_W+1:0]          rt_trial;
    logic                     rt_ok;
    logic [ACC_W-1:0]         quot;
    logic [ROOT_W-1:0]        root_fin;

    assign done = (state_reg == U_DONE);
    assign res  = res_reg;

    always_comb
    begin
        dv_r     = {rem_reg, acc_reg[ACC_W-1]};
        dv_ok    = dv_r >= {1'b0, k_reg};
        rt_t     = {srem_reg, acc_reg[ACC_W-1:ACC_W-2]};
        rt_trial = {2'b00, root_reg, 2'b01};
        rt_ok    = rt_t >= rt_trial;
        quot     = {acc_reg[ACC_W-2:0], dv_ok};
        root_fin = {root_reg[ROOT_W-2:0], rt_ok};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        k_next     = k_reg;
        mag_next   = mag_reg;
        msh_next   = msh_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        res_next   = res_reg;

        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    neg_next = req.value[RSUM_W-1];
                    k_next   = req.k;
                    mag_next = req.value[RSUM_W-1] ? RSUM_W'(-req.value) : RSUM_W'(req.value);
                    msh_next = req.value[RSUM_W-1] ? RSUM_W'(-req.value) : RSUM_W'(req.value);
                    rem_next = '0;
                    if (req.op == OP_MEAN)
                    begin
                        acc_next   = ACC_W'(req.value[RSUM_W-1] ? RSUM_W'(-req.value)
                                                               : RSUM_W'(req.value));
                        cnt_next   = CNT_UW'(ACC_W);
                        state_next = U_DV;
                    end
                    else
                    begin
                        acc_next   = '0;
                        cnt_next   = CNT_UW'(RSUM_W);
                        state_next = U_SQ;
                    end
                end
            end
            U_SQ:
            begin
                acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                           + (msh_reg[RSUM_W-1] ? ACC_W'(mag_reg) : '0);
                msh_next = {msh_reg[RSUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_UW'(1))
                begin
                    cnt_next   = CNT_UW'(ACC_W);
                    state_next = U_DV;
                end
            end
            U_DV:
            begin
                rem_next = dv_ok ? K_W'(dv_r - {1'b0, k_reg}) : K_W'(dv_r);
                acc_next = quot;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_UW'(1))
                begin
                    if (op_reg == OP_MEAN)
                    begin
                        res_next   = neg_reg ? -quot[SCORE_W-1:0] : quot[SCORE_W-1:0];
                        state_next = U_DONE;
                    end
                    else
                    begin
                        cnt_next   = CNT_UW'(ROOT_W);
                        srem_next  = '0;
                        root_next  = '0;
                        state_next = U_RT;
                    end
                end
            end
            U_RT:
            begin
                srem_next = rt_ok ? SR_W'(rt_t - rt_trial) : SR_W'(rt_t);
                root_next = root_fin;
                acc_next  = {acc_reg[ACC_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_UW'(1))
                begin
                    if (root_fin[ROOT_W-1:SCORE_W-1] != '0)
                    begin
                        res_next = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        res_next = neg_reg ? -root_fin[SCORE_W-1:0] : root_fin[SCORE_W-1:0];
                    end
                    state_next = U_DONE;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        k_reg    <= k_next;
        mag_reg  <= mag_next;
        msh_reg  <= msh_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

endmodule

[sv/grouped_min_median_or_reduction.sv]
// Top level of the grouped min/median/mean and max/sum/sum-over-root/probabilistic-or reduction.
// The item channel carries one gathered score per transaction with its validity flag and
// the end of group and end of reaction marks; the result channel carries one capacity per
// reaction, flagged not available when no group survived. Both use valid and stall.
// Mode registers are written through the plain write port; the user must write them
// only while the block is idle, which the block itself does not enforce. Items without
// an end mark stream back to back. An item that closes a group holds off the next item
// while the group is closed: minimum mode goes on to the combine and finish states, a
// dropped group goes straight to finish, median mode shifts the score chain toward
// cell zero before taking the median, and mean mode waits for the bit-serial divider.
// Closing a reaction passes through the finish and emit states; in sum over square root
// mode it also waits while the same serial unit squares, divides and takes the root one
// bit per cycle. The result sits in an output register; the next items are accepted
// while it waits; only a further end of reaction waits until the receiver takes it.
// Reset clears the counters, modes and reaction state; the score chain is not cleared.
module grouped_min_median_or_reduction #(
    parameter int MAX_GENES_PER_GROUP     = gmmr_pkg::MAX_GENES_DEFAULT,
    parameter int MAX_GROUPS_PER_REACTION = gmmr_pkg::MAX_GROUPS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  gmmr_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gmmr_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [gmmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmmr_pkg::MODE_W-1:0]       cfg_data
);
    import gmmr_pkg::*;

    localparam int NG    = MAX_GENES_PER_GROUP;
    localparam int CNT_W = $clog2(NG + 1);
    localparam int SG_W  = $clog2(MAX_GROUPS_PER_REACTION + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLOSE = 9'b000000010,
        S_SHIFT = 9'b000000100,
        S_MED   = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_COMB  = 9'b000100000,
        S_FIN   = 9'b001000000,
        S_SQW   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [MODE_W-1:0]         and_mode_reg, or_mode_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          shcnt_reg, shcnt_next;
    logic signed [GSUM_W-1:0]  gsum_reg, gsum_next;
    logic                      ginv_reg, ginv_next;
    logic                      endr_reg, endr_next;
    logic signed [SCORE_W-1:0] val_reg, val_next;
    logic signed [SCORE_W-1:0] rmax_reg, rmax_next;
    logic signed [RSUM_W-1:0]  rsum_reg, rsum_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [SG_W-1:0]           surv_reg, surv_next;
    logic signed [SCORE_W-1:0] cap_reg, cap_next;
    logic                      na_reg, na_next;
    logic                      res_valid_reg, res_valid_next;
    result_t                   res_reg, res_next;

    cell_ctrl_t                ctrl;
    unit_req_t                 ureq;
    logic                      udone;
    logic signed [SCORE_W-1:0] ures;
    logic signed [SCORE_W-1:0] cell_val [NG];
    logic                      cell_gt  [NG];

    logic                      accept;
    logic                      do_ins;
    logic                      out_free;
    logic signed [SCORE_W:0]   med_sum;
    logic signed [SCORE_W:0]   med_half;
    logic signed [RSUM_W:0]    rsum_add;
    logic [PROD_W-1:0]         clamp_b;
    logic [2*PROD_W-1:0]       prod_mul;
    logic [CNT_W-1:0]          half_cnt;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign do_ins       = accept && item.has_gene && item.score_valid
                          && (count_reg < CNT_W'(NG));
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign ctrl.ins     = do_ins;
    assign ctrl.shift   = (state_reg == S_SHIFT);
    assign ctrl.ins_val = item.gene_score;

    for (genvar i = 0; i < NG; i++)
    begin : g_cell
        gmmr_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (CNT_W'(i) < count_reg),
            .at_count  (CNT_W'(i) == count_reg),
            .left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .left_val  (cell_val[(i == 0) ? 0 : i - 1]),
            .right_val (cell_val[(i == NG - 1) ? i : i + 1]),
            .val       (cell_val[i]),
            .gt        (cell_gt[i])
        );
    end

    gmmr_serial u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .done  (udone),
        .res   (ures)
    );

    always_comb
    begin
        half_cnt = count_reg >> 1;
        med_sum  = {cell_val[0][SCORE_W-1], cell_val[0]}
                   + {cell_val[1 % NG][SCORE_W-1], cell_val[1 % NG]};
        med_half = (med_sum + (SCORE_W + 1)'(med_sum[SCORE_W])) >>> 1;
        rsum_add = {rsum_reg[RSUM_W-1], rsum_reg}
                   + (RSUM_W + 1)'(signed'(val_reg));
        if (val_reg[SCORE_W-1])
        begin
            clamp_b = '0;
        end
        else if (val_reg > signed'(SCORE_W'(ONE_FX)))
        begin
            clamp_b = ONE_FX;
        end
        else
        begin
            clamp_b = PROD_W'(val_reg);
        end
        prod_mul = prod_reg * (ONE_FX - clamp_b);

        ureq.start = 1'b0;
        ureq.op    = OP_MEAN;
        ureq.value = RSUM_W'(gsum_reg);
        ureq.k     = K_W'(count_reg);

        state_next     = state_reg;
        count_next     = count_reg;
        shcnt_next     = shcnt_reg;
        gsum_next      = gsum_reg;
        ginv_next      = ginv_reg;
        endr_next      = endr_reg;
        val_next       = val_reg;
        rmax_next      = rmax_reg;
        rsum_next      = rsum_reg;
        prod_next      = prod_reg;
        surv_next      = surv_reg;
        cap_next       = cap_reg;
        na_next        = na_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (do_ins)
                    begin
                        count_next = count_reg + 1'b1;
                        gsum_next  = gsum_reg + GSUM_W'(item.gene_score);
                    end
                    else if (item.has_gene)
                    begin
                        ginv_next = 1'b1;
                    end
                    endr_next = item.end_reaction;
                    if (item.end_group || item.end_reaction)
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_CLOSE:
            begin
                if (count_reg == '0 || ginv_reg)
                begin
                    count_next = '0;
                    gsum_next  = '0;
                    ginv_next  = 1'b0;
                    state_next = S_FIN;
                end
                else if (and_mode_reg == AND_MIN)
                begin
                    val_next   = cell_val[0];
                    state_next = S_COMB;
                end
                else if (and_mode_reg == AND_MEAN)
                begin
                    ureq.start = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    shcnt_next = count_reg[0] ? half_cnt : half_cnt - 1'b1;
                    if ((count_reg[0] ? half_cnt : half_cnt - 1'b1) == '0)
                    begin
                        state_next = S_MED;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                shcnt_next = shcnt_reg - 1'b1;
                if (shcnt_reg == CNT_W'(1))
                begin
                    state_next = S_MED;
                end
            end
            S_MED:
            begin
                val_next   = count_reg[0] ? cell_val[0] : med_half[SCORE_W-1:0];
                state_next = S_COMB;
            end
            S_WAIT:
            begin
                if (udone)
                begin
                    val_next   = ures;
                    state_next = S_COMB;
                end
            end
            S_COMB:
            begin
                if (surv_reg < SG_W'(MAX_GROUPS_PER_REACTION))
                begin
                    if (surv_reg == '0 || val_reg > rmax_reg)
                    begin
                        rmax_next = val_reg;
                    end
                    if (rsum_add[RSUM_W] != rsum_add[RSUM_W-1])
                    begin
                        rsum_next = rsum_add[RSUM_W] ? {1'b1, {(RSUM_W-1){1'b0}}}
                                                     : {1'b0, {(RSUM_W-1){1'b1}}};
                    end
                    else
                    begin
                        rsum_next = rsum_add[RSUM_W-1:0];
                    end
                    prod_next = prod_mul[FRAC_BITS +: PROD_W];
                    surv_next = surv_reg + 1'b1;
                end
                count_next = '0;
                gsum_next  = '0;
                ginv_next  = 1'b0;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!endr_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    na_next    = (surv_reg == '0);
                    state_next = S_EMIT;
                    if (surv_reg == '0)
                    begin
                        cap_next = '0;
                    end
                    else
                    begin
                        case (or_mode_reg)
                            OR_MAX:  cap_next = rmax_reg;
                            OR_PROB: cap_next = SCORE_W'(ONE_FX - prod_reg);
                            OR_SUM:  cap_next = sat32(rsum_reg);
                            OR_SQRT:
                            begin
                                ureq.start = 1'b1;
                                ureq.op    = OP_SQRT;
                                ureq.value = rsum_reg;
                                ureq.k     = K_W'(surv_reg);
                                state_next = S_SQW;
                            end
                            default: cap_next = rmax_reg;
                        endcase
                    end
                end
            end
            S_SQW:
            begin
                if (udone)
                begin
                    cap_next   = ures;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.capacity    = cap_reg;
                    res_next.capacity_na = na_reg;
                    rmax_next            = '0;
                    rsum_next            = '0;
                    prod_next            = ONE_FX;
                    surv_next            = '0;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            and_mode_reg  <= AND_MIN;
            or_mode_reg   <= OR_MAX;
            count_reg     <= '0;
            shcnt_reg     <= '0;
            gsum_reg      <= '0;
            ginv_reg      <= 1'b0;
            endr_reg      <= 1'b0;
            rmax_reg      <= '0;
            rsum_reg      <= '0;
            prod_reg      <= ONE_FX;
            surv_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            shcnt_reg     <= shcnt_next;
            gsum_reg      <= gsum_next;
            ginv_reg      <= ginv_next;
            endr_reg      <= endr_next;
            rmax_reg      <= rmax_next;
            rsum_reg      <= rsum_next;
            prod_reg      <= prod_next;
            surv_reg      <= surv_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_AND_MODE: and_mode_reg <= cfg_data;
                    CFG_OR_MODE:  or_mode_reg  <= cfg_data;
                    default:      and_mode_reg <= and_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        cap_reg <= cap_next;
        na_reg  <= na_next;
        res_reg <= res_next;
    end

endmodule

[sv/gmmr_checker.sv]
// Port-level assertion checker of the reduction block, bound to its top level.
`include "assert_macros.svh"

module gmmr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_stall,
    input gmmr_pkg::item_t                item,
    input logic                           result_valid,
    input logic                           result_stall,
    input gmmr_pkg::result_t              result
);

    logic item_take;
    logic item_ends;
    logic result_held;

    assign item_take   = item_valid && !item_stall;
    assign item_ends   = item.end_group || item.end_reaction;
    assign result_held = result_valid && result_stall;

    `ASSERT_CLK(a_result_held, result_held |=> result_valid, "Stalled result was dropped.")
    `ASSERT_CLK(a_result_stable, result_held |=> $stable(result), "Stalled result changed.")
    `ASSERT_CLK(a_plain_streams, item_take && !item_ends |=> !item_stall, "Plain item blocked.")
    `ASSERT_CLK(a_close_busy, item_take && item_ends |=> item_stall, "Group close not held.")
    `ASSERT_CLK(a_na_zero, result_valid && result.capacity_na |-> result.capacity == 0, "NA nonzero.")

endmodule

bind grouped_min_median_or_reduction gmmr_checker u_gmmr_checker (.*);
